// ----- rtl/core/bpc_pkg.sv -----
// ----------------------------------------------------------------------------
// bpc_pkg
// shared constants and types for the barometric compensation pipeline
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int C_LAT      = 84;
    localparam int C_S_TEMP   = 5;
    localparam int C_S_DZERO  = 13;
    localparam int C_DIV_LAT  = 66;

    localparam int C_T_OFF    = 128000;
    localparam int C_P_OFF    = 1048576;
    localparam int C_P_SCALE  = 3125;

    typedef enum logic [1:0] {
        REG_TCAL = 2'd0,
        REG_PCL  = 2'd1,
        REG_PCH  = 2'd2,
        REG_P9   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [19:0] ap;
        logic [31:0] tc;
        logic [31:0] tf;
        logic        dz;
    } t_side;

endpackage

// ----- rtl/core/bpc_mul16.sv -----
// ----------------------------------------------------------------------------
// bpc_mul16
// 64-bit by 17-bit signed wrapping multiply, two register stages
// ----------------------------------------------------------------------------
module bpc_mul16 (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [63:0]        i_a,
    input  logic signed [16:0] i_b,
    output logic [63:0]        o_p
);

    logic signed [49:0] n_lo;
    logic signed [48:0] n_hi;
    logic signed [49:0] r_lo;
    logic [31:0]        r_hi;
    logic [63:0]        r_p;

    assign n_lo = $signed({1'b0, i_a[31:0]}) * i_b;
    assign n_hi = $signed(i_a[63:32]) * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lo <= n_lo;
            r_hi <= n_hi[31:0];
            r_p  <= {{14{r_lo[49]}}, r_lo} + {r_hi, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/bpc_mul64.sv -----
// ----------------------------------------------------------------------------
// bpc_mul64
// 64-bit by 64-bit wrapping multiply from 32-bit partial products
// ----------------------------------------------------------------------------
module bpc_mul64 (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic [63:0] o_p
);

    logic [63:0] n_ll;
    logic [63:0] n_lh;
    logic [63:0] n_hl;
    logic [63:0] r_ll;
    logic [31:0] r_lh;
    logic [31:0] r_hl;
    logic [63:0] r_p;

    assign n_ll = i_a[31:0] * i_b[31:0];
    assign n_lh = i_a[31:0] * i_b[63:32];
    assign n_hl = i_a[63:32] * i_b[31:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= n_ll;
            r_lh <= n_lh[31:0];
            r_hl <= n_hl[31:0];
            r_p  <= r_ll + {r_lh + r_hl, 32'd0};
        end
    end

    assign o_p = r_p;

endmodule

// ----- rtl/core/bpc_div.sv -----
// ----------------------------------------------------------------------------
// bpc_div
// pipelined signed 64-bit divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module bpc_div (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_num,
    input  logic [63:0] i_den,
    output logic [63:0] o_quot
);

    logic [63:0] r_rem [0:64];
    logic [63:0] r_qn  [0:64];
    logic [63:0] r_dd  [0:64];
    logic        r_sg  [0:64];
    logic [63:0] r_quot;

    logic [63:0] n_rem [1:64];
    logic [63:0] n_qn  [1:64];

    always_comb begin
        logic [64:0] n_trial;
        logic [64:0] n_diff;
        for (int k = 0; k < 64; k++) begin
            n_trial    = {r_rem[k], r_qn[k][63]};
            n_diff     = n_trial - {1'b0, r_dd[k]};
            n_rem[k+1] = n_diff[64] ? n_trial[63:0] : n_diff[63:0];
            n_qn[k+1]  = {r_qn[k][62:0], ~n_diff[64]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= 64'd0;
            r_qn[0]  <= i_num[63] ? (64'd0 - i_num) : i_num;
            r_dd[0]  <= i_den[63] ? (64'd0 - i_den) : i_den;
            r_sg[0]  <= i_num[63] ^ i_den[63];
            r_quot   <= r_sg[64] ? (64'd0 - r_qn[64]) : r_qn[64];
            for (int k = 0; k < 64; k++) begin
                r_rem[k+1] <= n_rem[k+1];
                r_qn[k+1]  <= n_qn[k+1];
                r_dd[k+1]  <= r_dd[k];
                r_sg[k+1]  <= r_sg[k];
            end
        end
    end

    assign o_quot = r_quot;

endmodule

// ----- rtl/core/baro_temp_pressure_compensation_top.sv -----
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_top
// fixed-point temperature and pressure compensation for a barometric sensor
// ----------------------------------------------------------------------------
// input stream: one raw temperature and one raw pressure sample per
// transaction; output stream: temperature in 0.01 degC, fine temperature,
// pressure in Pa as Q24.8 in tdata, and the pressure-valid flag in tuser.
// calibration words are written over the APB port; the user must write
// them only while the block is idle, which the block does not enforce.
// one sample pair is accepted per cycle while the output is not stalled.
// the pipeline holds a 64-stage restoring divider and multiply stages.
// reset clears the calibration registers and all stage valid bits.
// when the output is stalled the whole pipeline holds and s_axis_tready
// drops until the result is taken; no sample is lost or repeated.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_top
    import bpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // raw_temperature, raw_pressure
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata,  // temperature_centi, fine_temperature, pressure_q24_8
    output logic [0:0]  m_axis_tuser   // pressure_valid
);

    logic [47:0] r_tcal;
    logic [63:0] r_pcl;
    logic [63:0] r_pch;
    logic [15:0] r_p9;

    logic               w_en;
    logic [C_LAT:1]     r_vld;
    t_side              r_side [1:C_LAT-1];

    logic [15:0]        w_t1;
    logic signed [15:0] w_t2, w_t3;
    logic [15:0]        w_p1;
    logic signed [15:0] w_p2, w_p3, w_p4, w_p5, w_p6, w_p7, w_p8, w_p9;

    // calibration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tcal <= '0;
            r_pcl  <= '0;
            r_pch  <= '0;
            r_p9   <= '0;
        end else if (psel && penable && pwrite) begin
            case (t_reg_idx'(paddr[4:3]))
                REG_TCAL: r_tcal <= pwdata[47:0];
                REG_PCL:  r_pcl  <= pwdata;
                REG_PCH:  r_pch  <= pwdata;
                REG_P9:   r_p9   <= pwdata[15:0];
                default:  r_p9   <= r_p9;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[4:3]))
            REG_TCAL: prdata = {16'd0, r_tcal};
            REG_PCL:  prdata = r_pcl;
            REG_PCH:  prdata = r_pch;
            REG_P9:   prdata = {48'd0, r_p9};
            default:  prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign w_t1 = r_tcal[15:0];
    assign w_t2 = r_tcal[31:16];
    assign w_t3 = r_tcal[47:32];
    assign w_p1 = r_pcl[15:0];
    assign w_p2 = r_pcl[31:16];
    assign w_p3 = r_pcl[47:32];
    assign w_p4 = r_pcl[63:48];
    assign w_p5 = r_pch[15:0];
    assign w_p6 = r_pch[31:16];
    assign w_p7 = r_pch[47:32];
    assign w_p8 = r_pch[63:48];
    assign w_p9 = r_p9;

    // pipeline advance and valid line
    assign w_en          = ~r_vld[C_LAT] | m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[C_LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[C_LAT-1:1], s_axis_tvalid};
        end
    end

    // temperature stages
    logic signed [17:0] r1_a;
    logic signed [16:0] r1_d;
    logic signed [33:0] r2_m1, r2_m2;
    logic signed [31:0] r3_v1t;
    logic signed [47:0] r3_m3;
    logic signed [31:0] r4_tf;
    logic signed [33:0] r5_v1p;

    logic signed [31:0] n3_v2a;
    logic signed [47:0] n3_m3;
    logic [31:0]        n5_x;
    logic [31:0]        n5_tc;

    assign n3_v2a = $signed(r2_m2[31:0]) >>> 12;
    assign n3_m3  = n3_v2a * w_t3;
    assign n5_x   = {r4_tf[29:0], 2'b00} + r4_tf + 32'd128;
    assign n5_tc  = $signed(n5_x) >>> 8;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_a   <= $signed({1'b0, s_axis_tdata[19:3]}) - $signed({1'b0, w_t1, 1'b0});
            r1_d   <= $signed({1'b0, s_axis_tdata[19:4]}) - $signed({1'b0, w_t1});
            r2_m1  <= r1_a * w_t2;
            r2_m2  <= r1_d * r1_d;
            r3_v1t <= $signed(r2_m1[31:0]) >>> 11;
            r3_m3  <= n3_m3;
            r4_tf  <= r3_v1t + ($signed(r3_m3[31:0]) >>> 14);
            r5_v1p <= {{2{r4_tf[31]}}, r4_tf} - 34'(C_T_OFF);
        end
    end

    // pressure stages before the divider
    logic signed [67:0] n6_sq;
    logic [63:0]        r6_sq;
    logic signed [49:0] r6_m5, r6_m2p, r7_m5, r7_m2p, r8_m5, r8_m2p;
    logic [63:0]        w_sq6, w_sq3;
    logic [63:0]        r9_v2, r9_a;
    logic [20:0]        n10_pn;
    logic [63:0]        r10_x, r10_num;
    logic [63:0]        w_xp1, w_num;
    logic [63:0]        n13_den;
    logic [63:0]        r13_den, r13_num;

    assign n6_sq = r5_v1p * r5_v1p;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_sq   <= n6_sq[63:0];
            r6_m5   <= r5_v1p * w_p5;
            r6_m2p  <= r5_v1p * w_p2;
            r7_m5   <= r6_m5;
            r7_m2p  <= r6_m2p;
            r8_m5   <= r7_m5;
            r8_m2p  <= r7_m2p;
            r9_v2   <= w_sq6 + ({{14{r8_m5[49]}}, r8_m5} << 17)
                       + ({{48{w_p4[15]}}, w_p4} << 35);
            r9_a    <= 64'($signed(w_sq3) >>> 8) + ({{14{r8_m2p[49]}}, r8_m2p} << 12);
            r10_x   <= r9_a + (64'd1 << 47);
            r10_num <= ({43'd0, n10_pn} << 31) - r9_v2;
            r13_den <= n13_den;
            r13_num <= w_num;
        end
    end

    assign n10_pn  = 21'(C_P_OFF) - {1'b0, r_side[9].ap};
    assign n13_den = 64'($signed(w_xp1) >>> 33);

    bpc_mul16 u_mul_p6 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r6_sq),
        .i_b   ({w_p6[15], w_p6}), .o_p (w_sq6)
    );

    bpc_mul16 u_mul_p3 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r6_sq),
        .i_b   ({w_p3[15], w_p3}), .o_p (w_sq3)
    );

    bpc_mul16 u_mul_p1 (
        .i_clk (i_clk), .i_en (w_en), .i_a (r10_x),
        .i_b   ({1'b0, w_p1}), .o_p (w_xp1)
    );

    bpc_mul16 u_mul_scale (
        .i_clk (i_clk), .i_en (w_en), .i_a (r10_num),
        .i_b   (17'(C_P_SCALE)), .o_p (w_num)
    );

    // division
    logic [63:0] w_q;

    bpc_div u_div (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_num  (r13_num),
        .i_den  (r13_den),
        .o_quot (w_q)
    );

    // pressure stages after the divider
    logic [63:0] n_q13;
    logic [63:0] r80_q, r80_q13, r81_q, r81_q13;
    logic [63:0] w_t9, w_p8q, w_tq;
    logic [63:0] r82_q, r82_p8q, r83_q, r83_p8q;
    logic [63:0] n_v1, n_v2, n_sum, n_pr;
    logic [31:0] r_o_tc, r_o_tf, r_o_pr;
    logic        r_o_pv;

    assign n_q13 = 64'($signed(w_q) >>> 13);

    bpc_mul16 u_mul_p9 (
        .i_clk (i_clk), .i_en (w_en), .i_a (n_q13),
        .i_b   ({w_p9[15], w_p9}), .o_p (w_t9)
    );

    bpc_mul16 u_mul_p8 (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_q),
        .i_b   ({w_p8[15], w_p8}), .o_p (w_p8q)
    );

    bpc_mul64 u_mul_sq (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_t9),
        .i_b   (r81_q13), .o_p (w_tq)
    );

    assign n_v1  = 64'($signed(w_tq) >>> 25);
    assign n_v2  = 64'($signed(r83_p8q) >>> 19);
    assign n_sum = r83_q + n_v1 + n_v2;
    assign n_pr  = 64'($signed(n_sum) >>> 8) + ({{48{w_p7[15]}}, w_p7} << 4);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r80_q   <= w_q;
            r80_q13 <= n_q13;
            r81_q   <= r80_q;
            r81_q13 <= r80_q13;
            r82_q   <= r81_q;
            r82_p8q <= w_p8q;
            r83_q   <= r82_q;
            r83_p8q <= r82_p8q;
            r_o_tc  <= r_side[C_LAT-1].tc;
            r_o_tf  <= r_side[C_LAT-1].tf;
            r_o_pr  <= r_side[C_LAT-1].dz ? 32'd0 : n_pr[31:0];
            r_o_pv  <= ~r_side[C_LAT-1].dz;
        end
    end

    // sideband line
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[1] <= '{ap: s_axis_tdata[39:20], tc: 32'd0, tf: 32'd0, dz: 1'b0};
            for (int k = 2; k < C_LAT; k++) begin
                if (k == C_S_TEMP) begin
                    r_side[k] <= '{ap: r_side[k-1].ap, tc: n5_tc, tf: r4_tf,
                                   dz: r_side[k-1].dz};
                end else if (k == C_S_DZERO) begin
                    r_side[k] <= '{ap: r_side[k-1].ap, tc: r_side[k-1].tc,
                                   tf: r_side[k-1].tf, dz: (n13_den == 64'd0)};
                end else begin
                    r_side[k] <= r_side[k-1];
                end
            end
        end
    end

    assign m_axis_tdata = {r_o_pr, r_o_tf, r_o_tc};
    assign m_axis_tuser = r_o_pv;

    a_zero_press : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[95:64] == 32'd0)
        else $error("pressure not cleared for zero divisor");

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_vld[1])
        else $error("accepted sample missing from first stage");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> r_vld == $past(r_vld))
        else $error("valid line moved during stall");

    a_last_reaches : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[C_LAT-1] && w_en |=> m_axis_tvalid)
        else $error("result lost before output register");

endmodule
